### rtl/sbq_pkg.sv
// Package: sizes, codes and shared types of the semaphore blocked queue table.
`timescale 1ns / 1ps
package sbq_pkg;

   localparam int NUM_PROCS       = 32;
   localparam int NUM_DESCRIPTORS = 32;
   localparam int KEY_BITS        = 32;
   localparam int PROC_BITS       = $clog2(NUM_PROCS);
   localparam int DESC_BITS       = $clog2(NUM_DESCRIPTORS);

   typedef logic [PROC_BITS-1:0] proc_idx_type;
   typedef logic [DESC_BITS-1:0] desc_idx_type;
   typedef logic [KEY_BITS-1:0]  key_type;

   typedef enum logic [1:0] {
      OP_INSERT       = 2'd0,
      OP_REMOVE_HEAD  = 2'd1,
      OP_REMOVE_GIVEN = 2'd2,
      OP_PEEK         = 2'd3
   } op_code_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO_KEY  = 3'd1,
      ST_BLOCKED   = 3'd2,
      ST_NO_DESC   = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_code_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_DECODE,
      SQ_INS_TAIL,
      SQ_GIVEN_DESC,
      SQ_HEAD,
      SQ_UNLINK
   } seq_state_type;

   // Queue ends of one descriptor, kept together in one memory word
   typedef struct packed {
      proc_idx_type head;
      proc_idx_type tail;
   } desc_entry_type;

   // Result of the associative lookup
   typedef struct packed {
      logic         hit;
      desc_idx_type idx;
      logic         free_hit;
      desc_idx_type free_idx;
   } sbq_match_type;

endpackage

### rtl/sbq_ram.sv
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module sbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port: hold the last word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sbq_cam.sv
// Descriptor key store with associative match and lowest-free selection.
`timescale 1ns / 1ps
module sbq_cam import sbq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  key_type       key,
   input  logic          alloc_en,
   input  desc_idx_type  alloc_idx,
   input  key_type       alloc_key,
   input  logic          free_en,
   input  desc_idx_type  free_idx,
   output sbq_match_type match
);

   key_type key_ff [NUM_DESCRIPTORS];
   logic [NUM_DESCRIPTORS-1:0] in_use_ff;

   // store the key of a new descriptor
   always_ff @(posedge clock) begin
      if (alloc_en) begin
         key_ff[alloc_idx] <= alloc_key;
      end
   end

   // track occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         if (alloc_en) begin
            in_use_ff[alloc_idx] <= 1'b1;
         end
         if (free_en) begin
            in_use_ff[free_idx] <= 1'b0;
         end
      end
   end

   // compare against every live descriptor; pick the lowest free slot
   always_comb begin
      match = '0;
      for (int i = 0; i < NUM_DESCRIPTORS; i++) begin
         if (in_use_ff[i] && key_ff[i] == key) begin
            match.hit = 1'b1;
            match.idx = DESC_BITS'(i);
         end
      end
      for (int i = NUM_DESCRIPTORS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            match.free_hit = 1'b1;
            match.free_idx = DESC_BITS'(i);
         end
      end
   end

endmodule

### rtl/semaphore_blocked_queue_table_unit.sv
// Top level: request sequencer over the key match and the link memories.
// Requests settled by the key match finish in the decode state; insert on a known key
// or peek also reads the descriptor word, remove-head reads it and then the waiter links,
// and remove-given reads the waiter's descriptor index and links, then the descriptor word.
// One request at a time: req_stall is high until the sequencer is back in idle.
// Reset (synchronous, active high) frees every descriptor and unblocks every process.
`timescale 1ns / 1ps
module semaphore_blocked_queue_table_unit import sbq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_sem_key,
   input  logic [4:0]  req_proc_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_result_proc,
   output logic        rsp_result_valid
);

   seq_state_type state_ff, state_in;
   op_code_type   op_ff;
   key_type       key_ff;
   logic [4:0]    pid_ff;
   proc_idx_type  p_ff, p_in;
   desc_idx_type  d_ff, d_in;
   logic [NUM_PROCS-1:0] blocked_ff;

   logic            rsp_valid_ff, rsp_result_valid_ff, rsp_load, rsp_res_valid_in;
   status_code_type rsp_status_ff, rsp_status_in;
   proc_idx_type    rsp_proc_ff, rsp_proc_in;
   logic            out_ok;

   sbq_match_type  match;
   logic           alloc_en, free_en;
   desc_idx_type   free_idx;

   logic           desc_wr_en, desc_rd_en, proc_rd_en;
   desc_idx_type   desc_wr_addr, desc_rd_addr;
   desc_entry_type desc_wr_data, desc_rdata;
   proc_idx_type   proc_rd_addr;
   logic           next_wr_en, prev_wr_en, bdesc_wr_en;
   proc_idx_type   next_wr_addr, next_wr_data, prev_wr_addr, prev_wr_data, bdesc_wr_addr;
   desc_idx_type   bdesc_wr_data, bdesc_rdata;
   proc_idx_type   next_rdata, prev_rdata;
   logic           blk_set, blk_clr;
   proc_idx_type   blk_idx;

   logic           key_zero, proc_ok, blk_p, is_head, is_tail;
   proc_idx_type   p_idx;
   desc_entry_type entry;

   assign out_ok    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != SQ_IDLE);
   assign key_zero  = (key_ff == '0);
   assign proc_ok   = (32'(pid_ff) < NUM_PROCS);
   assign p_idx     = pid_ff[PROC_BITS-1:0];
   assign blk_p     = blocked_ff[p_idx];
   assign is_head   = (desc_rdata.head == p_ff);
   assign is_tail   = (desc_rdata.tail == p_ff);

   sbq_cam u_cam (
      .clock     (clock),
      .reset     (reset),
      .key       (key_ff),
      .alloc_en  (alloc_en),
      .alloc_idx (match.free_idx),
      .alloc_key (key_ff),
      .free_en   (free_en),
      .free_idx  (free_idx),
      .match     (match)
   );

   sbq_ram #(.WIDTH($bits(desc_entry_type)), .DEPTH(NUM_DESCRIPTORS)) u_desc_ram (
      .clock (clock), .wr_en (desc_wr_en), .wr_addr (desc_wr_addr), .wr_data (desc_wr_data),
      .rd_en (desc_rd_en), .rd_addr (desc_rd_addr), .rd_data (desc_rdata)
   );

   sbq_ram #(.WIDTH(PROC_BITS), .DEPTH(NUM_PROCS)) u_next_ram (
      .clock (clock), .wr_en (next_wr_en), .wr_addr (next_wr_addr), .wr_data (next_wr_data),
      .rd_en (proc_rd_en), .rd_addr (proc_rd_addr), .rd_data (next_rdata)
   );

   sbq_ram #(.WIDTH(PROC_BITS), .DEPTH(NUM_PROCS)) u_prev_ram (
      .clock (clock), .wr_en (prev_wr_en), .wr_addr (prev_wr_addr), .wr_data (prev_wr_data),
      .rd_en (proc_rd_en), .rd_addr (proc_rd_addr), .rd_data (prev_rdata)
   );

   sbq_ram #(.WIDTH(DESC_BITS), .DEPTH(NUM_PROCS)) u_bdesc_ram (
      .clock (clock), .wr_en (bdesc_wr_en), .wr_addr (bdesc_wr_addr), .wr_data (bdesc_wr_data),
      .rd_en (proc_rd_en), .rd_addr (proc_rd_addr), .rd_data (bdesc_rdata)
   );

   // next state; one request in flight, so no two accesses overlap
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (req_valid) begin
               state_in = SQ_DECODE;
            end
         end
         SQ_DECODE: begin
            case (op_ff)
               OP_INSERT: begin
                  if (!key_zero && proc_ok && !blk_p && match.hit) begin
                     state_in = SQ_INS_TAIL;
                  end else if (out_ok) begin
                     state_in = SQ_IDLE;
                  end
               end
               OP_REMOVE_GIVEN: begin
                  if (proc_ok && blk_p) begin
                     state_in = SQ_GIVEN_DESC;
                  end else if (out_ok) begin
                     state_in = SQ_IDLE;
                  end
               end
               default: begin
                  if (!key_zero && match.hit) begin
                     state_in = SQ_HEAD;
                  end else if (out_ok) begin
                     state_in = SQ_IDLE;
                  end
               end
            endcase
         end
         SQ_INS_TAIL: begin
            if (out_ok) begin
               state_in = SQ_IDLE;
            end
         end
         SQ_GIVEN_DESC: state_in = SQ_UNLINK;
         SQ_HEAD: begin
            if (op_ff == OP_REMOVE_HEAD) begin
               state_in = SQ_UNLINK;
            end else if (out_ok) begin
               state_in = SQ_IDLE;
            end
         end
         SQ_UNLINK: begin
            if (out_ok) begin
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   // memory accesses, table updates and result per state
   always_comb begin
      p_in             = p_ff;
      d_in             = d_ff;
      alloc_en         = 1'b0;
      free_en          = 1'b0;
      free_idx         = d_ff;
      desc_rd_en       = 1'b0;
      desc_rd_addr     = d_ff;
      desc_wr_en       = 1'b0;
      desc_wr_addr     = d_ff;
      desc_wr_data     = desc_rdata;
      proc_rd_en       = 1'b0;
      proc_rd_addr     = p_ff;
      next_wr_en       = 1'b0;
      next_wr_addr     = p_ff;
      next_wr_data     = p_ff;
      prev_wr_en       = 1'b0;
      prev_wr_addr     = p_ff;
      prev_wr_data     = p_ff;
      bdesc_wr_en      = 1'b0;
      bdesc_wr_addr    = p_ff;
      bdesc_wr_data    = d_ff;
      blk_set          = 1'b0;
      blk_clr          = 1'b0;
      blk_idx          = p_ff;
      rsp_load         = 1'b0;
      rsp_status_in    = ST_OK;
      rsp_proc_in      = '0;
      rsp_res_valid_in = 1'b0;
      entry            = desc_rdata;
      case (state_ff)
         SQ_DECODE: begin
            p_in = p_idx;
            d_in = match.idx;
            case (op_ff)
               OP_INSERT: begin
                  if (key_zero) begin
                     rsp_load      = out_ok;
                     rsp_status_in = ST_ZERO_KEY;
                  end else if (!proc_ok) begin
                     rsp_load      = out_ok;
                     rsp_status_in = ST_NOT_FOUND;
                  end else if (blk_p) begin
                     rsp_load      = out_ok;
                     rsp_status_in = ST_BLOCKED;
                  end else if (match.hit) begin
                     desc_rd_en   = 1'b1;
                     desc_rd_addr = match.idx;
                  end else if (!match.free_hit) begin
                     rsp_load      = out_ok;
                     rsp_status_in = ST_NO_DESC;
                  end else begin
                     // new key: take the lowest free descriptor
                     rsp_load      = out_ok;
                     alloc_en      = out_ok;
                     desc_wr_en    = out_ok;
                     desc_wr_addr  = match.free_idx;
                     desc_wr_data  = '{head: p_idx, tail: p_idx};
                     bdesc_wr_en   = out_ok;
                     bdesc_wr_addr = p_idx;
                     bdesc_wr_data = match.free_idx;
                     blk_set       = out_ok;
                     blk_idx       = p_idx;
                  end
               end
               OP_REMOVE_GIVEN: begin
                  if (!proc_ok || !blk_p) begin
                     rsp_load      = out_ok;
                     rsp_status_in = ST_NOT_FOUND;
                  end else begin
                     proc_rd_en   = 1'b1;
                     proc_rd_addr = p_idx;
                  end
               end
               default: begin
                  if (key_zero) begin
                     rsp_load      = out_ok;
                     rsp_status_in = ST_ZERO_KEY;
                  end else if (!match.hit) begin
                     rsp_load      = out_ok;
                     rsp_status_in = ST_NOT_FOUND;
                  end else begin
                     desc_rd_en   = 1'b1;
                     desc_rd_addr = match.idx;
                  end
               end
            endcase
         end
         SQ_INS_TAIL: begin
            // append behind the current tail
            rsp_load      = out_ok;
            next_wr_en    = out_ok;
            next_wr_addr  = desc_rdata.tail;
            next_wr_data  = p_ff;
            prev_wr_en    = out_ok;
            prev_wr_addr  = p_ff;
            prev_wr_data  = desc_rdata.tail;
            desc_wr_en    = out_ok;
            desc_wr_data  = '{head: desc_rdata.head, tail: p_ff};
            bdesc_wr_en   = out_ok;
            blk_set       = out_ok;
         end
         SQ_GIVEN_DESC: begin
            d_in         = bdesc_rdata;
            desc_rd_en   = 1'b1;
            desc_rd_addr = bdesc_rdata;
         end
         SQ_HEAD: begin
            p_in = desc_rdata.head;
            if (op_ff == OP_REMOVE_HEAD) begin
               proc_rd_en   = 1'b1;
               proc_rd_addr = desc_rdata.head;
            end else begin
               rsp_load         = out_ok;
               rsp_proc_in      = desc_rdata.head;
               rsp_res_valid_in = 1'b1;
            end
         end
         SQ_UNLINK: begin
            // splice the process out; free the descriptor when it empties
            rsp_load         = out_ok;
            rsp_proc_in      = p_ff;
            rsp_res_valid_in = 1'b1;
            blk_clr          = out_ok;
            if (is_head && is_tail) begin
               free_en = out_ok;
            end else begin
               if (is_head) begin
                  entry.head = next_rdata;
               end else begin
                  next_wr_en   = out_ok;
                  next_wr_addr = prev_rdata;
                  next_wr_data = next_rdata;
               end
               if (is_tail) begin
                  entry.tail = prev_rdata;
               end else begin
                  prev_wr_en   = out_ok;
                  prev_wr_addr = next_rdata;
                  prev_wr_data = prev_rdata;
               end
               desc_wr_en   = out_ok && (is_head || is_tail);
               desc_wr_data = entry;
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the request and working indices
   always_ff @(posedge clock) begin
      if (state_ff == SQ_IDLE && req_valid) begin
         op_ff  <= op_code_type'(req_type);
         key_ff <= req_sem_key[KEY_BITS-1:0];
         pid_ff <= req_proc_id;
      end
      p_ff <= p_in;
      d_ff <= d_in;
   end

   // blocked flags
   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= '0;
      end else if (blk_set) begin
         blocked_ff[blk_idx] <= 1'b1;
      end else if (blk_clr) begin
         blocked_ff[blk_idx] <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff       <= rsp_status_in;
         rsp_proc_ff         <= rsp_proc_in;
         rsp_result_valid_ff <= rsp_res_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_proc  = 5'(rsp_proc_ff);
   assign rsp_result_valid = rsp_result_valid_ff;

`ifndef NO_ASSERTIONS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != SQ_IDLE |-> req_stall)
      else $error("request taken while a request is in flight");

   a_proc_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_result_valid_ff |-> rsp_status_ff == ST_OK)
      else $error("process returned with a failure status");

   a_unlink_unblocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == SQ_UNLINK && out_ok |=> !blocked_ff[$past(p_ff)])
      else $error("unlinked process still marked blocked");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> state_in == SQ_IDLE)
      else $error("result produced before the request completes");
`endif

endmodule

### tb/semaphore_blocked_queue_table_unit_tb.sv
// Testbench: semaphore blocked queue table against a behavioral table model.
`timescale 1ns / 1ps
module semaphore_blocked_queue_table_unit_tb import sbq_pkg::*;;

   typedef struct {
      status_code_type status;
      logic [4:0]      proc;
      logic            valid;
   } sem_answer_type;

   // Behavioral table model and the queue of answers still owed by the block
   class sem_table_scoreboard;
      logic [31:0] desc_key [NUM_DESCRIPTORS];
      bit          desc_used [NUM_DESCRIPTORS];
      logic [4:0]  head_of [NUM_DESCRIPTORS];
      logic [4:0]  tail_of [NUM_DESCRIPTORS];
      logic [4:0]  next_of [NUM_PROCS];
      logic [4:0]  prev_of [NUM_PROCS];
      logic [31:0] waits_on [NUM_PROCS];
      int          desc_of [NUM_PROCS];
      sem_answer_type owed [$];
      int          mismatches;

      function new();
         mismatches = 0;
         foreach (desc_used[i]) desc_used[i] = 0;
         foreach (waits_on[i]) waits_on[i] = '0;
      endfunction

      function int find_key(logic [31:0] key);
         foreach (desc_used[d])
            if (desc_used[d] && desc_key[d] == key) return d;
         return -1;
      endfunction

      function void unlink(int d, logic [4:0] p);
         logic [4:0] nx, pv;
         bit         at_head, at_tail;
         nx = next_of[p];
         pv = prev_of[p];
         at_head = (head_of[d] == p);
         at_tail = (tail_of[d] == p);
         if (at_head && at_tail) begin
            desc_used[d] = 0;
         end else begin
            if (at_head) head_of[d] = nx; else next_of[pv] = nx;
            if (at_tail) tail_of[d] = pv; else prev_of[nx] = pv;
         end
         waits_on[p] = '0;
      endfunction

      // Note one accepted request: update the table and push its answer
      function void note_request(op_code_type op, logic [31:0] key, logic [4:0] pid);
         sem_answer_type a;
         int          d;
         a.status = ST_OK;
         a.proc = '0;
         a.valid = 0;
         if (op == OP_INSERT) begin
            if (key == 0) a.status = ST_ZERO_KEY;
            else if (waits_on[pid] != 0) a.status = ST_BLOCKED;
            else begin
               d = find_key(key);
               if (d >= 0) begin
                  next_of[tail_of[d]] = pid;
                  prev_of[pid] = tail_of[d];
                  tail_of[d] = pid;
               end else begin
                  d = 0;
                  while (d < NUM_DESCRIPTORS && desc_used[d]) d++;
                  if (d < NUM_DESCRIPTORS) begin
                     desc_used[d] = 1;
                     desc_key[d] = key;
                     head_of[d] = pid;
                     tail_of[d] = pid;
                  end
               end
               if (d >= NUM_DESCRIPTORS) a.status = ST_NO_DESC;
               else begin
                  waits_on[pid] = key;
                  desc_of[pid] = d;
               end
            end
         end else if (op == OP_REMOVE_GIVEN) begin
            if (waits_on[pid] == 0) a.status = ST_NOT_FOUND;
            else begin
               unlink(desc_of[pid], pid);
               a.proc = pid;
               a.valid = 1;
            end
         end else begin
            d = find_key(key);
            if (key == 0) a.status = ST_ZERO_KEY;
            else if (d < 0) a.status = ST_NOT_FOUND;
            else begin
               a.proc = head_of[d];
               a.valid = 1;
               if (op == OP_REMOVE_HEAD) unlink(d, head_of[d]);
            end
         end
         owed.push_back(a);
      endfunction

      // Check one result transfer against the oldest owed answer
      function void check_answer(logic [2:0] st, logic [4:0] pr, logic vl);
         sem_answer_type a;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer st=%0d", st);
            return;
         end
         a = owed.pop_front();
         if (st !== a.status || pr !== a.proc || vl !== a.valid) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: exp st=%0d proc=%0d v=%0d got st=%0d proc=%0d v=%0d",
                        a.status, a.proc, a.valid, st, pr, vl);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_type = '0;
   logic [31:0] req_sem_key = '0;
   logic [4:0]  req_proc_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_status;
   logic [4:0]  rsp_result_proc;
   logic        rsp_result_valid;

   sem_table_scoreboard tracker = new();
   bit   quiet_phase = 0;
   bit   hold_rsp = 0;
   logic [31:0] key_pool [8];

   semaphore_blocked_queue_table_unit dut (.*);

   always #10 clock = ~clock;

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         tracker.note_request(op_code_type'(req_type), req_sem_key, req_proc_id);
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_answer(rsp_status, rsp_result_proc, rsp_result_valid);
   end

   // Receiver stall: random bursts, or held during a long hold-off
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1;
            @(negedge clock);
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            rsp_stall <= 1;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_stall <= 0;
            @(negedge clock);
         end
      end
   end

   // Offer one request and hold it until transferred, with random gaps before it
   task automatic send_request(op_code_type op, logic [31:0] key, logic [4:0] pid);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_type <= op;
      req_sem_key <= key;
      req_proc_id <= pid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_answers();
      req_valid <= 0;
      while (tracker.owed.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Mostly pool keys so queues build up; some zero and random keys
   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return $urandom;
      return key_pool[$urandom_range(0, 7)];
   endfunction

   task automatic random_request();
      int r;
      op_code_type op;
      r = $urandom_range(0, 9);
      op = (r < 4) ? OP_INSERT : (r < 6) ? OP_REMOVE_HEAD :
           (r < 8) ? OP_REMOVE_GIVEN : OP_PEEK;
      send_request(op, pick_key(), 5'($urandom_range(0, 31)));
   endtask

   initial begin
      int i;
      key_pool[0] = 32'hFFFF_FFFF;
      key_pool[1] = 32'h0000_0001;
      for (i = 2; i < 8; i++) key_pool[i] = $urandom | 32'h1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: errors on empty table, then a queue on one key
      send_request(OP_PEEK, 32'h0, 5'd0);
      send_request(OP_REMOVE_HEAD, 32'h0, 5'd0);
      send_request(OP_INSERT, 32'h0, 5'd3);
      send_request(OP_PEEK, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_REMOVE_HEAD, 32'h1234, 5'd0);
      send_request(OP_REMOVE_GIVEN, 32'h0, 5'd31);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd31);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd7);
      send_request(OP_INSERT, 32'h1, 5'd31);
      send_request(OP_PEEK, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_REMOVE_GIVEN, 32'h0, 5'd31);
      send_request(OP_REMOVE_HEAD, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_REMOVE_HEAD, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_PEEK, 32'hFFFF_FFFF, 5'd0);

      // Fill every descriptor: 32 distinct keys, then retry blocked processes
      for (i = 0; i < 32; i++) send_request(OP_INSERT, 32'h100 + i, 5'(i));
      send_request(OP_INSERT, 32'h5000, 5'd0);
      send_request(OP_INSERT, 32'h5000, 5'd31);
      for (i = 0; i < 32; i++) send_request(OP_REMOVE_GIVEN, 32'h0, 5'(i));
      drain_answers();

      // Long receiver hold-off while requests keep coming
      fork
         begin
            hold_rsp = 1;
            repeat (60) @(negedge clock);
            hold_rsp = 0;
         end
         for (i = 0; i < 20; i++) random_request();
      join
      drain_answers();

      for (i = 0; i < 800; i++) random_request();
      drain_answers();
      quiet_phase = 1;
      for (i = 0; i < 200; i++) random_request();
      drain_answers();

      if (tracker.mismatches == 0 && tracker.owed.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #4ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

### semaphore_blocked_queue_table_unit.f
rtl/sbq_pkg.sv
rtl/sbq_ram.sv
rtl/sbq_cam.sv
rtl/semaphore_blocked_queue_table_unit.sv
tb/semaphore_blocked_queue_table_unit_tb.sv
